### hdl/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// rcsp_pkg: shared types and constants of the reader-counted slot publisher
// Holds the command and status codes, the controller states and the records
// that pass between the controller and the row of slot cells.
// ----------------------------------------------------------------------------
package rcsp_pkg;

    localparam int SLOT_BITS = 4;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PUBLISH = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NONE      = 2'd1,
        STATUS_NOFREE    = 2'd2,
        STATUS_COUNT_ERR = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        COUNT_HOLD = 2'd0,
        COUNT_INC  = 2'd1,
        COUNT_DEC  = 2'd2
    } count_op_t;

    typedef struct packed {
        count_op_t             count_op;
        logic [SLOT_BITS-1:0]  target;
        logic                  tok_load;
        logic                  tok_shift;
        logic [SLOT_BITS-1:0]  tok_start;
    } cell_ctl_t;

endpackage

### hdl/rcsp_req_if.sv
// ----------------------------------------------------------------------------
// rcsp_req_if: request channel of the slot publisher
// Valid/ready channel that carries one command per transfer.
// ----------------------------------------------------------------------------
interface rcsp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] slot;
    logic       content_valid;

    modport source (output valid, output command, output slot, output content_valid,
                    input ready);
    modport sink   (input valid, input command, input slot, input content_valid,
                    output ready);
endinterface

### hdl/rcsp_rsp_if.sv
// ----------------------------------------------------------------------------
// rcsp_rsp_if: response channel of the slot publisher
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface rcsp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] granted_slot;

    modport source (output valid, output status, output granted_slot, input ready);
    modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

### hdl/reader_counted_slot_publisher.sv
// ----------------------------------------------------------------------------
// Responses: acquire, release, clear and rejected publish answer in the cycle
// after the request transfer; a publish search answers once the search token
// finds a cell with no readers or has passed the last cell of its walk.
// Throughput: one request per cycle while responses are taken; a publish of
// valid content holds the request channel until the token walk ends.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// reader_counted_slot_publisher: top level
// A ring of slot cells with reader counts, driven by a command sequencer.
// Reset clears every reader count and the published mark.
// ----------------------------------------------------------------------------
module reader_counted_slot_publisher #(
    parameter int SLOT_COUNT = 3,
    parameter int COUNT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    rcsp_req_if.sink   req,
    rcsp_rsp_if.source rsp
);

    rcsp_pkg::cell_ctl_t   ctl;
    logic [SLOT_COUNT-1:0] zero_vec;
    logic [SLOT_COUNT-1:0] full_vec;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] tok_vec;

    rcsp_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .zero_vec (zero_vec),
        .full_vec (full_vec),
        .hit_vec  (hit_vec),
        .ctl      (ctl)
    );

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        rcsp_cell #(
            .COUNT_BITS (COUNT_BITS),
            .IDX        (rcsp_pkg::SLOT_BITS'(i))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok_vec[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
            .tok_out (tok_vec[i]),
            .zero    (zero_vec[i]),
            .full    (full_vec[i]),
            .hit     (hit_vec[i])
        );
    end

endmodule

### hdl/rcsp_cell.sv
// ----------------------------------------------------------------------------
// rcsp_cell: one slot of the ring
// Keeps the reader count of its slot and one bit of the search token, which
// it hands to the next cell of the ring on every search step.
// ----------------------------------------------------------------------------
module rcsp_cell #(
    parameter int                             COUNT_BITS = 8,
    parameter logic [rcsp_pkg::SLOT_BITS-1:0] IDX        = '0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rcsp_pkg::cell_ctl_t ctl,
    input  logic                tok_in,
    output logic                tok_out,
    output logic                zero,
    output logic                full,
    output logic                hit
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  tok_reg;
    logic                  tok_next;
    logic                  selected;

    assign selected = (ctl.target == IDX);

    always_comb
    begin
        count_next = count_reg;
        if (selected)
        begin
            case (ctl.count_op)
                rcsp_pkg::COUNT_INC: count_next = count_reg + COUNT_BITS'(1);
                rcsp_pkg::COUNT_DEC: count_next = count_reg - COUNT_BITS'(1);
                default:             count_next = count_reg;
            endcase
        end
        tok_next = tok_reg;
        if (ctl.tok_load)
        begin
            tok_next = (ctl.tok_start == IDX);
        end
        else if (ctl.tok_shift)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign zero    = (count_reg == '0);
    assign full    = (count_reg == '1);
    assign hit     = tok_reg & zero;

endmodule

### hdl/rcsp_ctrl.sv
// ----------------------------------------------------------------------------
// rcsp_ctrl: command sequencer of the slot publisher
// Decodes requests, drives the cell row, walks the publish search token and
// holds the published slot and the response register.
// ----------------------------------------------------------------------------
module rcsp_ctrl #(
    parameter int SLOT_COUNT = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    rcsp_req_if.sink                req,
    rcsp_rsp_if.source              rsp,
    input  logic [SLOT_COUNT-1:0]   zero_vec,
    input  logic [SLOT_COUNT-1:0]   full_vec,
    input  logic [SLOT_COUNT-1:0]   hit_vec,
    output rcsp_pkg::cell_ctl_t     ctl
);

    localparam int OFF_BITS = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [rcsp_pkg::SLOT_BITS-1:0] LAST_SLOT =
        rcsp_pkg::SLOT_BITS'(SLOT_COUNT - 1);
    localparam logic [OFF_BITS-1:0] LAST_OFF = OFF_BITS'(SLOT_COUNT - 1);

    rcsp_pkg::state_t                state_reg;
    rcsp_pkg::state_t                state_next;
    logic [OFF_BITS-1:0]             off_reg;
    logic [OFF_BITS-1:0]             off_next;
    logic [rcsp_pkg::SLOT_BITS-1:0]  pidx_reg;
    logic [rcsp_pkg::SLOT_BITS-1:0]  pidx_next;
    logic                            present_reg;
    logic                            present_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    rcsp_pkg::status_t               status_reg;
    rcsp_pkg::status_t               status_next;
    logic [rcsp_pkg::SLOT_BITS-1:0]  granted_reg;
    logic [rcsp_pkg::SLOT_BITS-1:0]  granted_next;

    logic                            accept;
    logic [rcsp_pkg::SLOT_BITS-1:0]  base;
    logic [rcsp_pkg::SLOT_BITS-1:0]  start;
    logic                            pidx_full;
    logic                            slot_zero;
    logic [rcsp_pkg::SLOT_BITS-1:0]  found;

    assign req.ready = (state_reg == rcsp_pkg::S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign base      = present_reg ? pidx_reg : '0;
    assign start     = (base == LAST_SLOT) ? '0 : base + rcsp_pkg::SLOT_BITS'(1);

    always_comb
    begin
        pidx_full = 1'b0;
        slot_zero = 1'b0;
        found     = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pidx_reg == rcsp_pkg::SLOT_BITS'(i))
            begin
                pidx_full = full_vec[i];
            end
            if (req.slot == rcsp_pkg::SLOT_BITS'(i))
            begin
                slot_zero = zero_vec[i];
            end
            if (hit_vec[i])
            begin
                found = found | rcsp_pkg::SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        pidx_next      = pidx_reg;
        present_next   = present_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ctl            = '{count_op: rcsp_pkg::COUNT_HOLD, target: '0, tok_load: 1'b0,
                           tok_shift: 1'b0, tok_start: start};

        unique case (state_reg)
            rcsp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rcsp_pkg::STATUS_OK;
                    granted_next   = '0;
                    unique case (rcsp_pkg::cmd_t'(req.command))
                        rcsp_pkg::CMD_ACQUIRE:
                        begin
                            if (!present_reg || pidx_reg > LAST_SLOT)
                            begin
                                status_next = rcsp_pkg::STATUS_NONE;
                            end
                            else if (pidx_full)
                            begin
                                status_next = rcsp_pkg::STATUS_COUNT_ERR;
                            end
                            else
                            begin
                                ctl.count_op = rcsp_pkg::COUNT_INC;
                                ctl.target   = pidx_reg;
                                granted_next = pidx_reg;
                            end
                        end
                        rcsp_pkg::CMD_RELEASE:
                        begin
                            if (req.slot > LAST_SLOT || slot_zero)
                            begin
                                status_next = rcsp_pkg::STATUS_COUNT_ERR;
                            end
                            else
                            begin
                                ctl.count_op = rcsp_pkg::COUNT_DEC;
                                ctl.target   = req.slot;
                            end
                        end
                        rcsp_pkg::CMD_PUBLISH:
                        begin
                            if (!req.content_valid)
                            begin
                                status_next = rcsp_pkg::STATUS_NONE;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                ctl.tok_load   = 1'b1;
                                off_next       = OFF_BITS'(1);
                                state_next     = rcsp_pkg::S_SEARCH;
                            end
                        end
                        rcsp_pkg::CMD_CLEAR:
                        begin
                            present_next = 1'b0;
                        end
                        default:
                        begin
                            present_next = present_reg;
                        end
                    endcase
                end
            end
            rcsp_pkg::S_SEARCH:
            begin
                if (|hit_vec)
                begin
                    pidx_next      = found;
                    present_next   = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = rcsp_pkg::STATUS_OK;
                    granted_next   = found;
                    state_next     = rcsp_pkg::S_IDLE;
                end
                else if (off_reg == LAST_OFF)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rcsp_pkg::STATUS_NOFREE;
                    granted_next   = '0;
                    state_next     = rcsp_pkg::S_IDLE;
                end
                else
                begin
                    ctl.tok_shift = 1'b1;
                    off_next      = off_reg + OFF_BITS'(1);
                end
            end
            default:
            begin
                state_next = rcsp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcsp_pkg::S_IDLE;
            off_reg       <= '0;
            pidx_reg      <= '0;
            present_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_reg       <= off_next;
            pidx_reg      <= pidx_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.granted_slot = granted_reg;

endmodule

### hdl/rcsp_checker.sv
// ----------------------------------------------------------------------------
// rcsp_checker: port-level checks of the slot publisher
// Watches the request and response channels and flags protocol and result
// errors.
// ----------------------------------------------------------------------------
module rcsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_command,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [3:0] rsp_granted_slot
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Response was dropped before its transfer.");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_granted_slot))
        else $error("Stalled response changed.");

    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != rcsp_pkg::STATUS_OK |-> rsp_granted_slot == 4'd0)
        else $error("Failed command reported a slot.");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_command == rcsp_pkg::CMD_CLEAR
        |=> rsp_valid && rsp_status == rcsp_pkg::STATUS_OK && rsp_granted_slot == 4'd0)
        else $error("Clear did not answer ok in the next cycle.");

endmodule

bind reader_counted_slot_publisher rcsp_checker u_rcsp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_command      (req.command),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_granted_slot (rsp.granted_slot)
);
